>>> hdl/frc_pkg.sv
// shared types, constants and symbol tables for the four-wheel rotor cipher
package frc_pkg;

   localparam int NUM_SYMS   = 51;
   localparam int NUM_WHEELS = 4;
   localparam int POS_W      = 6;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 6;

   // wheel positions run 0..51; 51 wraps to 0 and carries into the next wheel
   localparam logic [POS_W-1:0] POS_WRAP  = 6'd51;
   localparam logic [POS_W-1:0] POS_LAST  = 6'd50;
   localparam logic [7:0]       UNKNOWN_CHAR = 8'h2A;

   localparam logic [CSR_IDX_W-1:0] CSR_MODE_DECRYPT = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS0   = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS1   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS2   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_START_POS3   = 3'd4;

   localparam logic [8*NUM_SYMS-1:0] ALPHA =
      "abcdefghijklmnopqrstuvwxyz0123456789!\"$'()+\\,-./?\n ";

   localparam logic [8*NUM_SYMS-1:0] ROTOR [NUM_WHEELS] = '{
      "bcagdefhilkjomnrqpu vstwzyx.94/3,20!\\?\n81\"5'+$(6)-7",
      "chtzwefdbyiqljuvskgaxorpnm\"6-(1$873,04 /.!25'\\+?)9\n",
      "x6pr8g7+2!n0$dw\\z?\n4lhya5mo.v)9-,1 (3sqiu'etb\"jcfk/",
      "j\"kbcefpl?/,v6gw(2!0o.5yamh1 -7r3s8x)9u$i+t\\z'qdn4\n"
   };

   typedef logic [POS_W-1:0] pos_type;
   typedef pos_type [NUM_WHEELS-1:0] wheel_pos_type;

   typedef struct packed {
      logic [7:0] in_char;
      logic       message_start;
   } req_type;

   typedef struct packed {
      logic [7:0] out_char;
      logic       unknown_symbol;
   } rsp_type;

   typedef struct packed {
      logic    found;
      pos_type idx;
   } sym_type;

   // character at an alphabet index; indexes past the alphabet give the unknown mark
   function automatic logic [7:0] alpha_char(input pos_type idx);
      logic [7:0] ch;
      ch = UNKNOWN_CHAR;
      if (int'(idx) < NUM_SYMS) begin
         ch = ALPHA[8*(NUM_SYMS-1-int'(idx)) +: 8];
      end
      return ch;
   endfunction

   function automatic sym_type char_lookup(input logic [7:0] ch);
      sym_type r;
      r = '0;
      for (int i = 0; i < NUM_SYMS; i++) begin
         if (ALPHA[8*(NUM_SYMS-1-i) +: 8] == ch) begin
            r.found = 1'b1;
            r.idx   = POS_W'(i);
         end
      end
      return r;
   endfunction

   function automatic pos_type rotor_fwd(input int k, input pos_type i);
      sym_type    s;
      logic [7:0] ch;
      ch = 8'h00;
      if (int'(i) < NUM_SYMS) begin
         ch = ROTOR[k][8*(NUM_SYMS-1-int'(i)) +: 8];
      end
      s = char_lookup(ch);
      return s.found ? s.idx : '0;
   endfunction

   function automatic pos_type rotor_inv(input int k, input pos_type v);
      pos_type r;
      r = '0;
      for (int i = 0; i < NUM_SYMS; i++) begin
         if (rotor_fwd(k, POS_W'(i)) == v) begin
            r = POS_W'(i);
         end
      end
      return r;
   endfunction

   function automatic pos_type add_mod(input pos_type p, input pos_type w);
      logic [POS_W:0] s;
      s = {1'b0, p} + {1'b0, w};
      if (s >= (POS_W+1)'(NUM_SYMS)) begin
         s = s - (POS_W+1)'(NUM_SYMS);
      end
      return s[POS_W-1:0];
   endfunction

   // difference wraps in two's complement; a negative result gets the modulus back
   function automatic pos_type sub_mod(input pos_type p, input pos_type w);
      logic [POS_W:0] s;
      s = {1'b0, p} - {1'b0, w};
      if (s[POS_W]) begin
         s = s + (POS_W+1)'(NUM_SYMS);
      end
      return s[POS_W-1:0];
   endfunction

endpackage

>>> hdl/four_rotor_cipher_top.sv
// top level of the four-wheel rotor cipher: handshake, wheel state and config registers
//
// One character per transaction, one result per character. A transaction is
// captured in an input register, goes through the four-wheel substitution
// logic and lands in the result register once that register is empty or its
// result is being taken; a new character is taken every cycle while results
// are drained. The four-wheel lookup chain between the two registers sets
// the clock period. Wheel positions step after every character, unknown ones
// included; a character with message_start set reloads the positions from
// the start registers first (values above 50 load as 50). Config writes take
// effect at once and belong between messages, with no transaction in flight.
module four_rotor_cipher_top (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  frc_pkg::req_type                 req_data,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output frc_pkg::rsp_type                 rsp_data,
   input  logic                             csr_we,
   input  logic [frc_pkg::CSR_IDX_W-1:0]    csr_idx,
   input  logic [frc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                   req_valid_ff, req_valid_in;
   frc_pkg::req_type       req_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   frc_pkg::rsp_type       rsp_ff, rsp_in;
   frc_pkg::wheel_pos_type wheel_ff, wheel_in;
   frc_pkg::wheel_pos_type start_ff, start_in;
   logic                   mode_ff, mode_in;

   frc_pkg::wheel_pos_type cur_pos;
   logic                   advance;
   logic                   carry;

   assign advance   = req_valid_ff && (!rsp_valid_ff || rsp_ready);
   assign req_ready = !req_valid_ff || advance;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // positions in use for the character in the input register
   always_comb begin
      for (int k = 0; k < frc_pkg::NUM_WHEELS; k++) begin
         if (req_ff.message_start) begin
            cur_pos[k] = (start_ff[k] > frc_pkg::POS_LAST) ? frc_pkg::POS_LAST : start_ff[k];
         end else begin
            cur_pos[k] = wheel_ff[k];
         end
      end
   end

   frc_core u_core (
      .mode_decrypt (mode_ff),
      .wheel_pos    (cur_pos),
      .in_char      (req_ff.in_char),
      .rsp          (rsp_in)
   );

   // odometer step: wheel 0 always moves, carries ripple on wrap
   always_comb begin
      wheel_in = wheel_ff;
      carry    = 1'b1;
      if (advance) begin
         for (int k = 0; k < frc_pkg::NUM_WHEELS; k++) begin
            if (carry) begin
               if (cur_pos[k] == frc_pkg::POS_WRAP) begin
                  wheel_in[k] = '0;
               end else begin
                  wheel_in[k] = cur_pos[k] + frc_pkg::POS_W'(1);
                  carry       = 1'b0;
               end
            end else begin
               wheel_in[k] = cur_pos[k];
            end
         end
      end
   end

   always_comb begin
      mode_in  = mode_ff;
      start_in = start_ff;
      if (csr_we) begin
         case (csr_idx)
            frc_pkg::CSR_MODE_DECRYPT: mode_in     = csr_wdata[0];
            frc_pkg::CSR_START_POS0:   start_in[0] = csr_wdata;
            frc_pkg::CSR_START_POS1:   start_in[1] = csr_wdata;
            frc_pkg::CSR_START_POS2:   start_in[2] = csr_wdata;
            frc_pkg::CSR_START_POS3:   start_in[3] = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      req_valid_in = req_ready ? req_valid : req_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         wheel_ff     <= '0;
         start_ff     <= '0;
         mode_ff      <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         wheel_ff     <= wheel_in;
         start_ff     <= start_in;
         mode_ff      <= mode_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         req_ff <= req_data;
      end
      if (advance) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

>>> hdl/frc_core.sv
// combinational character transform through the four wheels
module frc_core (
   input  logic                  mode_decrypt,
   input  frc_pkg::wheel_pos_type wheel_pos,
   input  logic [7:0]            in_char,
   output frc_pkg::rsp_type      rsp
);

   logic [7:0]       lowered;
   frc_pkg::sym_type sym;
   frc_pkg::pos_type p;

   always_comb begin
      lowered = in_char;
      if (in_char >= 8'h41 && in_char <= 8'h5A) begin
         lowered = in_char + 8'h20;
      end
      sym = frc_pkg::char_lookup(lowered);
      p   = sym.idx;
      if (!mode_decrypt) begin
         // last wheel first
         for (int k = frc_pkg::NUM_WHEELS-1; k >= 0; k--) begin
            p = frc_pkg::rotor_fwd(k, frc_pkg::add_mod(p, wheel_pos[k]));
         end
      end else begin
         for (int k = 0; k < frc_pkg::NUM_WHEELS; k++) begin
            p = frc_pkg::sub_mod(frc_pkg::rotor_inv(k, p), wheel_pos[k]);
         end
      end
      rsp.unknown_symbol = !sym.found;
      rsp.out_char       = sym.found ? frc_pkg::alpha_char(p) : frc_pkg::UNKNOWN_CHAR;
   end

endmodule

>>> bench/tb_top.sv
// testbench for the four-wheel rotor cipher: directed and random character streams, checked in order
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CLOCK_PERIOD     = 12;
   localparam int RUN_LIMIT_CYCLES = 100_000;
   // from all start positions at 50 this wraps wheel 1 and moves wheel 2 to 51
   localparam int LONG_MSG_LEN     = 100;
   localparam int PENDING_MAX      = 256;

   logic                           clock;
   logic                           reset     = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   frc_pkg::req_type               req_data  = '0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   frc_pkg::rsp_type               rsp_data;
   logic                           csr_we    = 1'b0;
   logic [frc_pkg::CSR_IDX_W-1:0]  csr_idx   = '0;
   logic [frc_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   four_rotor_cipher_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_idx   (csr_idx),
      .csr_wdata (csr_wdata)
   );

   // cipher model: symbol tables, register copies and wheel positions
   int         sym_of_char [256];
   logic [7:0] alpha_chars [frc_pkg::NUM_SYMS];
   int         wiring_fwd  [frc_pkg::NUM_WHEELS][frc_pkg::NUM_SYMS];
   int         wiring_inv  [frc_pkg::NUM_WHEELS][frc_pkg::NUM_SYMS];
   logic       decrypt_reg = 1'b0;
   logic [frc_pkg::CSR_DATA_W-1:0] start_pos_reg [frc_pkg::NUM_WHEELS] = '{default: '0};
   int         wheel_pos [frc_pkg::NUM_WHEELS] = '{default: 0};

   frc_pkg::req_type pending_chars [$];
   frc_pkg::rsp_type expected_outs [$];
   int      mismatches   = 0;
   int      results_seen = 0;
   bit      full_rate    = 1'b0;
   bit      hold_request = 1'b0;

   function automatic frc_pkg::rsp_type cipher_step(input frc_pkg::req_type t);
      frc_pkg::rsp_type r;
      int      c;
      int      p;
      if (t.message_start) begin
         for (int k = 0; k < frc_pkg::NUM_WHEELS; k++) begin
            wheel_pos[k] = (start_pos_reg[k] > frc_pkg::NUM_SYMS - 1) ?
                           frc_pkg::NUM_SYMS - 1 : start_pos_reg[k];
         end
      end
      c = t.in_char;
      if (c >= "A" && c <= "Z") begin
         c += 32;
      end
      p = sym_of_char[c];
      r.unknown_symbol = (p < 0);
      if (p < 0) begin
         r.out_char = "*";
      end else begin
         if (!decrypt_reg) begin
            for (int k = frc_pkg::NUM_WHEELS - 1; k >= 0; k--) begin
               p = wiring_fwd[k][(p + wheel_pos[k]) % frc_pkg::NUM_SYMS];
            end
         end else begin
            for (int k = 0; k < frc_pkg::NUM_WHEELS; k++) begin
               p = wiring_inv[k][p] - wheel_pos[k];
               if (p < 0) begin
                  p += frc_pkg::NUM_SYMS;
               end
            end
         end
         r.out_char = alpha_chars[p];
      end
      // odometer: each wheel counts 0..51, the last one wraps without carry
      wheel_pos[0]++;
      for (int k = 0; k < frc_pkg::NUM_WHEELS; k++) begin
         if (wheel_pos[k] > frc_pkg::NUM_SYMS) begin
            wheel_pos[k] = 0;
            if (k + 1 < frc_pkg::NUM_WHEELS) begin
               wheel_pos[k+1]++;
            end
         end
      end
      return r;
   endfunction

   function automatic logic [7:0] random_char();
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4, 5: return alpha_chars[$urandom_range(0, frc_pkg::NUM_SYMS - 1)];
         6:                return 8'($urandom_range(65, 90));
         7:                return "*";
         default:          return 8'($urandom_range(0, 255));
      endcase
   endfunction

   function automatic logic [frc_pkg::CSR_DATA_W-1:0] random_start_pos();
      case ($urandom_range(0, 5))
         0:       return '0;
         1:       return frc_pkg::CSR_DATA_W'(frc_pkg::NUM_SYMS - 1);
         2:       return frc_pkg::CSR_DATA_W'($urandom_range(frc_pkg::NUM_SYMS, 63));
         default: return frc_pkg::CSR_DATA_W'($urandom_range(0, 63));
      endcase
   endfunction

   task automatic report_mismatch(input string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
   endtask

   task automatic csr_write(input logic [frc_pkg::CSR_IDX_W-1:0] idx,
                            input logic [frc_pkg::CSR_DATA_W-1:0] data);
      @(posedge clock);
      csr_we    <= 1'b1;
      csr_idx   <= idx;
      csr_wdata <= data;
      case (idx)
         frc_pkg::CSR_MODE_DECRYPT: decrypt_reg = data[0];
         frc_pkg::CSR_START_POS0, frc_pkg::CSR_START_POS1,
         frc_pkg::CSR_START_POS2, frc_pkg::CSR_START_POS3: begin
            start_pos_reg[idx - frc_pkg::CSR_START_POS0] = data;
         end
         default: ;
      endcase
      @(posedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(negedge clock);
      while (pending_chars.size() != 0 || req_valid || expected_outs.size() != 0);
   endtask

   task automatic queue_char(input logic [7:0] ch, input logic fresh);
      frc_pkg::req_type t;
      while (pending_chars.size() >= PENDING_MAX) @(negedge clock);
      t.in_char       = ch;
      t.message_start = fresh;
      pending_chars.push_back(t);
   endtask

   task automatic queue_message(input int len, input bit fresh, input bit restarts);
      for (int i = 0; i < len; i++) begin
         queue_char(random_char(), (i == 0) ? fresh : (restarts && $urandom_range(0, 63) == 0));
      end
   endtask

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   // sender: bursts of random length separated by random gaps
   int burst_left = 1;
   int gap_left   = 0;

   always @(posedge clock) begin : driver
      logic             next_valid;
      frc_pkg::req_type next_data;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         next_valid = req_valid;
         next_data  = req_data;
         if (req_valid && req_ready) begin
            expected_outs.push_back(cipher_step(req_data));
            next_valid = 1'b0;
         end
         if (!next_valid) begin
            if (gap_left > 0 && !full_rate) begin
               gap_left--;
            end else if (pending_chars.size() != 0) begin
               next_data  = pending_chars.pop_front();
               next_valid = 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 24);
                  gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
               end
            end
         end
         req_valid <= next_valid;
         req_data  <= next_data;
      end
   end

   // receiver: stall pattern changes at random intervals, plus one long hold-off
   int stall_left = 0;
   int stall_kind = 0;
   int hold_left  = 0;
   bit hold_done  = 1'b0;

   always @(posedge clock) begin : monitor
      frc_pkg::rsp_type want;
      logic             next_ready;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_outs.size() == 0) begin
               report_mismatch($sformatf("result with nothing outstanding: out_char %h unknown %b",
                                         rsp_data.out_char, rsp_data.unknown_symbol));
            end else begin
               want = expected_outs.pop_front();
               if (rsp_data.out_char !== want.out_char) begin
                  report_mismatch($sformatf("out_char %h, expected %h",
                                            rsp_data.out_char, want.out_char));
               end
               if (rsp_data.unknown_symbol !== want.unknown_symbol) begin
                  report_mismatch($sformatf("unknown_symbol %b, expected %b",
                                            rsp_data.unknown_symbol, want.unknown_symbol));
               end
            end
            results_seen++;
         end
         if (hold_request && !hold_done) begin
            hold_done = 1'b1;
            hold_left = 400;
         end
         if (stall_left == 0) begin
            stall_kind = $urandom_range(0, 3);
            stall_left = $urandom_range(10, 80);
         end
         stall_left--;
         if (full_rate) begin
            next_ready = 1'b1;
         end else if (hold_left > 0) begin
            hold_left--;
            next_ready = 1'b0;
         end else begin
            case (stall_kind)
               0:       next_ready = 1'b1;
               1:       next_ready = $urandom_range(0, 1);
               2:       next_ready = ($urandom_range(0, 7) != 0);
               default: next_ready = ($urandom_range(0, 7) == 0);
            endcase
         end
         rsp_ready <= next_ready;
      end
   end

   initial begin : stimulus
      string      alphabet;
      string      wiring [frc_pkg::NUM_WHEELS];
      string      w;
      logic [7:0] directed [12];
      int         v;
      int         len;
      int         queued;
      bit         mid_message;
      bit         first;

      alphabet  = "abcdefghijklmnopqrstuvwxyz0123456789!\"$'()+\\,-./?\n ";
      wiring[0] = "bcagdefhilkjomnrqpu vstwzyx.94/3,20!\\?\n81\"5'+$(6)-7";
      wiring[1] = "chtzwefdbyiqljuvskgaxorpnm\"6-(1$873,04 /.!25'\\+?)9\n";
      wiring[2] = "x6pr8g7+2!n0$dw\\z?\n4lhya5mo.v)9-,1 (3sqiu'etb\"jcfk/";
      wiring[3] = "j\"kbcefpl?/,v6gw(2!0o.5yamh1 -7r3s8x)9u$i+t\\z'qdn4\n";

      for (int c = 0; c < 256; c++) begin
         sym_of_char[c] = -1;
      end
      // walk backwards so the first occurrence wins
      for (int i = frc_pkg::NUM_SYMS - 1; i >= 0; i--) begin
         alpha_chars[i]          = alphabet[i];
         sym_of_char[alphabet[i]] = i;
      end
      for (int k = 0; k < frc_pkg::NUM_WHEELS; k++) begin
         w = wiring[k];
         for (int i = 0; i < frc_pkg::NUM_SYMS; i++) begin
            v = sym_of_char[w[i]];
            wiring_fwd[k][i] = (v < 0) ? 0 : v;
            wiring_inv[k][i] = 0;
         end
         for (int i = frc_pkg::NUM_SYMS - 1; i >= 0; i--) begin
            wiring_inv[k][wiring_fwd[k][i]] = i;
         end
      end

      directed = '{"a", "Z", "9", "\"", "\\", "\n", " ", "*", "@", 8'h00, 8'hFF, "q"};

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed: encrypt from all-zero positions, then decrypt from the top positions
      csr_write(frc_pkg::CSR_MODE_DECRYPT, '0);
      for (int k = 0; k < frc_pkg::NUM_WHEELS; k++) begin
         csr_write(frc_pkg::CSR_IDX_W'(frc_pkg::CSR_START_POS0 + k), '0);
      end
      for (int i = 0; i < 12; i++) begin
         queue_char(directed[i], i == 0);
      end
      wait_drained();
      csr_write(frc_pkg::CSR_MODE_DECRYPT, frc_pkg::CSR_DATA_W'(1));
      for (int k = 0; k < frc_pkg::NUM_WHEELS; k++) begin
         csr_write(frc_pkg::CSR_IDX_W'(frc_pkg::CSR_START_POS0 + k),
                   frc_pkg::CSR_DATA_W'(frc_pkg::NUM_SYMS - 1));
      end
      for (int i = 0; i < 12; i++) begin
         queue_char(directed[i], i == 0);
      end
      wait_drained();

      for (int ph = 0; ph < 10; ph++) begin
         // some phases flip the mode and carry on with the current positions
         mid_message = (ph > 0) && ($urandom_range(0, 2) == 0);
         if (mid_message) begin
            csr_write(frc_pkg::CSR_MODE_DECRYPT,
                      frc_pkg::CSR_DATA_W'({$urandom_range(0, 31), !decrypt_reg}));
         end else begin
            csr_write(frc_pkg::CSR_MODE_DECRYPT, frc_pkg::CSR_DATA_W'($urandom_range(0, 63)));
            for (int k = 0; k < frc_pkg::NUM_WHEELS; k++) begin
               csr_write(frc_pkg::CSR_IDX_W'(frc_pkg::CSR_START_POS0 + k), random_start_pos());
            end
            if ($urandom_range(0, 2) == 0) begin
               csr_write(frc_pkg::CSR_IDX_W'(frc_pkg::CSR_START_POS3 + 1 + $urandom_range(0, 2)),
                         frc_pkg::CSR_DATA_W'($urandom_range(0, 63)));
            end
         end
         if (ph == 2) begin
            @(negedge clock);
            hold_request = 1'b1;
         end
         queued = 0;
         first  = 1'b1;
         while (queued < 50) begin
            len = ($urandom_range(0, 4) == 0) ? $urandom_range(53, 120) : $urandom_range(1, 30);
            queue_message(len, !(mid_message && first), 1'b1);
            first   = 1'b0;
            queued += len;
            if ($urandom_range(0, 9) == 0) begin
               wait_drained();
            end
         end
         wait_drained();
      end

      // one long message at full rate so the low wheels carry and wheel 1 wraps
      full_rate = 1'b1;
      csr_write(frc_pkg::CSR_MODE_DECRYPT, frc_pkg::CSR_DATA_W'($urandom_range(0, 1)));
      for (int k = 0; k < frc_pkg::NUM_WHEELS; k++) begin
         csr_write(frc_pkg::CSR_IDX_W'(frc_pkg::CSR_START_POS0 + k),
                   frc_pkg::CSR_DATA_W'(frc_pkg::NUM_SYMS - 1));
      end
      queue_message(LONG_MSG_LEN, 1'b1, 1'b0);
      wait_drained();
      full_rate = 1'b0;

      repeat (10) @(posedge clock);
      if (expected_outs.size() != 0) begin
         report_mismatch($sformatf("%0d results never arrived", expected_outs.size()));
      end
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   initial begin : watchdog
      #(RUN_LIMIT_CYCLES * CLOCK_PERIOD);
      $display("timeout after %0d cycles, %0d results seen", RUN_LIMIT_CYCLES, results_seen);
      $display("Test completed with failures");
      $finish;
   end

endmodule

>>> sim.f
hdl/frc_pkg.sv
hdl/frc_core.sv
hdl/four_rotor_cipher_top.sv
bench/tb_top.sv
